/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/wcm_pkg.sv */
// types and constants of the wavetable channel mixer
package wcm_pkg;

	localparam int CHANNELS    = 4;
	localparam int CH_W        = 2;
	localparam int TABLE_LEN   = 32;
	localparam int IDX_W       = 5;
	localparam int NUM_WAVES   = 8;
	localparam int WSEL_W      = 3;
	localparam int MEM_DEPTH   = NUM_WAVES * TABLE_LEN;
	localparam int MEM_AW      = WSEL_W + IDX_W;
	localparam int FRAC_W      = 8;
	localparam int STEP_W      = 20;
	localparam int VOL_IN_W    = 8;
	localparam int VOL_W       = 4;
	localparam int VOLUME_MAX  = 15;
	localparam int SAMPLE_W    = 12;
	localparam int PROD_W      = SAMPLE_W + VOL_W;
	localparam int SUM_W       = PROD_W + CH_W;
	localparam int HALF_W      = SUM_W - 1;
	localparam int OUTPUT_MAX  = 4095;
	localparam int LEVEL_W     = 14;
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP       = (2 ** RECIP_SHIFT) / VOLUME_MAX;
	localparam int RECIP_PW    = 32;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_SET   = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_MUTE  = 3'd4;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [CH_W-1:0]     channel;
		logic [STEP_W-1:0]   phase_step;
		logic [VOL_IN_W-1:0] volume;
		logic [WSEL_W-1:0]   wave_select;
		logic [IDX_W-1:0]    table_address;
		logic [SAMPLE_W-1:0] sample_value;
		logic                mute_value;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] dac_sample;
		logic                muted;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic              accept;
		logic              acc_clr;
		logic              clr_wr;
		logic [MEM_AW-1:0] clr_addr;
		logic              issue;
		logic [CH_W-1:0]   chan;
		logic              div1;
		logic              div2;
		logic              load_out;
		logic              out_muted;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mute;
		logic out_free;
	} dp_sts_t;

endpackage

/* rtl/core/wavetable_channel_mixer.sv */
// top level of the wavetable channel mixer
// four-channel wavetable synthesizer with fractional phase accumulators
// item channel: item_valid / item_stall / item; one word per operation
//   (tick, set channel, stop channel, write wave sample, set mute)
// result channel: result_valid / result_stall / result; one word per tick only
// set, stop, write and mute words complete in the cycle they are accepted
// a tick walks the channels one per cycle through the single wave memory
//   read port in MIX, then passes through DRAIN, the scale steps DIV1 and DIV2,
//   and FIN, which loads the result into the output register once the result
//   side is free; the next word is accepted only after FIN
// a muted tick goes straight to FIN and loads its result there once the result side is free, phases untouched
// after reset the wave memory is swept to zero with item_stall high
// channel state and mute flag clear at reset, nothing is lost mid-operation
// a stalled result holds in the output register; new items are still taken
//   while it waits, and the next tick parks before loading until it is taken
module wavetable_channel_mixer
	import wcm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// command and status between sequencer and datapath
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer: clear sweep, channel walk, scale steps, output handoff
	wcm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.opcode     (item.opcode),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath: channel registers, wave memory, mac, divider, output register
	wcm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* rtl/core/wcm_ctrl.sv */
// controller state machine of the wavetable channel mixer
`include "assert_macros.svh"

module wcm_ctrl
	import wcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic [2:0] opcode,
	output logic      item_stall,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MIX   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DIV1  = 3'd4;
	localparam logic [2:0] ST_DIV2  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [MEM_AW-1:0] clr_addr_q;
	logic [CH_W-1:0]   chan_q;
	logic              muted_q;
	logic              accept;
	logic              tick;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign tick       = accept && (opcode == OP_TICK);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_addr_q == MEM_AW'(MEM_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (tick)
					state_d = sts.mute ? ST_FIN : ST_MIX;
			end
			ST_MIX: begin
				if (chan_q == CH_W'(CHANNELS - 1))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DIV1;
			ST_DIV1:  state_d = ST_DIV2;
			ST_DIV2:  state_d = ST_FIN;
			ST_FIN: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_addr_q <= '0;
			chan_q     <= '0;
			muted_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (state_q == ST_MIX)
				chan_q <= chan_q + 1'b1;
			else
				chan_q <= '0;
			if (tick)
				muted_q <= sts.mute;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.acc_clr   = tick;
		cmd.clr_wr    = (state_q == ST_CLR);
		cmd.clr_addr  = clr_addr_q;
		cmd.issue     = (state_q == ST_MIX);
		cmd.chan      = chan_q;
		cmd.div1      = (state_q == ST_DIV1);
		cmd.div2      = (state_q == ST_DIV2);
		cmd.load_out  = (state_q == ST_FIN) && sts.out_free;
		cmd.out_muted = muted_q;
	end

	`ASSERT_CLK(a_tick_starts_mix, clk, arst_n,
		tick && !sts.mute |=> state_q == ST_MIX && chan_q == '0,
		"unmuted tick did not start the channel sweep")
	`ASSERT_CLK(a_muted_tick_skips_mix, clk, arst_n,
		tick && sts.mute |=> state_q == ST_FIN && muted_q,
		"muted tick did not go straight to output")
	`ASSERT_NEVER(a_no_accept_while_busy, clk, arst_n,
		accept && (state_q == ST_MIX || state_q == ST_CLR),
		"word accepted while the sweep or clear is running")

endmodule

/* rtl/core/wcm_dpath.sv */
// datapath of the wavetable channel mixer: channel state, wave memory, mix and scale
`include "assert_macros.svh"

module wcm_dpath
	import wcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     item,
	input  ctrl_cmd_t cmd,
	output dp_sts_t   sts,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	logic [STEP_W-1:0]   chan_step_q [CHANNELS];
	logic [VOL_W-1:0]    chan_vol_q  [CHANNELS];
	logic [FRAC_W-1:0]   chan_frac_q [CHANNELS];
	logic [IDX_W-1:0]    chan_idx_q  [CHANNELS];
	logic [WSEL_W-1:0]   chan_wave_q [CHANNELS];
	logic                mute_q;

	logic [SAMPLE_W-1:0] wave_mem [MEM_DEPTH];

	logic [SAMPLE_W-1:0] rd_data_s1;
	logic [VOL_W-1:0]    vol_s1;
	logic                mac_s1;
	logic [SUM_W-1:0]    acc_q;
	logic [HALF_W-1:0]   y_s2;
	logic [LEVEL_W-1:0]  q0_s2;
	logic [SAMPLE_W-1:0] level_q;
	logic                out_valid_q;
	result_t             out_q;

	logic                is_set, is_stop, is_write, is_mute;
	logic [VOL_W-1:0]    vol_clamped;
	logic [WSEL_W-1:0]   wave_checked;
	logic [STEP_W:0]     phase_sum;
	logic [IDX_W-1:0]    idx_next;
	logic [FRAC_W-1:0]   frac_next;
	logic [RECIP_PW-1:0] recip_prod;
	logic [HALF_W-1:0]   rem;
	logic [LEVEL_W-1:0]  quot;

	// opcode decode of the accepted word
	always_comb begin
		is_set   = 1'b0;
		is_stop  = 1'b0;
		is_write = 1'b0;
		is_mute  = 1'b0;
		unique case (item.opcode)
			OP_TICK:  ;
			OP_SET:   is_set   = cmd.accept;
			OP_STOP:  is_stop  = cmd.accept;
			OP_WRITE: is_write = cmd.accept;
			OP_MUTE:  is_mute  = cmd.accept;
			default:  ;
		endcase
	end

	assign vol_clamped  = (item.volume > VOL_IN_W'(VOLUME_MAX)) ? VOL_W'(VOLUME_MAX)
	                                                            : item.volume[VOL_W-1:0];
	assign wave_checked = (32'(item.wave_select) < NUM_WAVES) ? item.wave_select : '0;

	// phase advance of the channel being visited
	assign phase_sum = (STEP_W+1)'(chan_frac_q[cmd.chan]) + (STEP_W+1)'(chan_step_q[cmd.chan]);
	assign frac_next = phase_sum[FRAC_W-1:0];
	assign idx_next  = chan_idx_q[cmd.chan] + phase_sum[FRAC_W +: IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				chan_step_q[c] <= '0;
				chan_vol_q[c]  <= '0;
				chan_frac_q[c] <= '0;
				chan_idx_q[c]  <= '0;
				chan_wave_q[c] <= '0;
			end
			mute_q <= 1'b0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (is_set && 32'(item.channel) == c) begin
					chan_step_q[c] <= item.phase_step;
					chan_vol_q[c]  <= vol_clamped;
					chan_wave_q[c] <= wave_checked;
				end else if (is_stop && 32'(item.channel) == c) begin
					chan_step_q[c] <= '0;
					chan_vol_q[c]  <= '0;
					chan_frac_q[c] <= '0;
					chan_idx_q[c]  <= '0;
					chan_wave_q[c] <= '0;
				end else if (cmd.issue && 32'(cmd.chan) == c) begin
					chan_frac_q[c] <= frac_next;
					chan_idx_q[c]  <= idx_next;
				end
			end
			if (is_mute)
				mute_q <= item.mute_value;
		end
	end

	// wave memory, cleared by the controller sweep after reset
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			wave_mem[cmd.clr_addr] <= '0;
		else if (is_write && 32'(item.wave_select) < NUM_WAVES
		         && 32'(item.table_address) < TABLE_LEN)
			wave_mem[{item.wave_select, item.table_address}] <= item.sample_value;
		rd_data_s1 <= wave_mem[{chan_wave_q[cmd.chan], chan_idx_q[cmd.chan]}];
	end

	// multiply-accumulate one channel per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mac_s1 <= 1'b0;
		else
			mac_s1 <= cmd.issue;
	end

	always_ff @(posedge clk) begin
		vol_s1 <= chan_vol_q[cmd.chan];
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (mac_s1)
			acc_q <= acc_q + SUM_W'(PROD_W'(rd_data_s1) * PROD_W'(vol_s1));
	end

	// divide by twice the max volume: halve, then reciprocal estimate and one correction
	assign recip_prod = RECIP_PW'(acc_q[SUM_W-1:1]) * RECIP_PW'(RECIP);
	assign rem        = y_s2 - HALF_W'(HALF_W'(q0_s2) * HALF_W'(VOLUME_MAX));
	assign quot       = q0_s2 + LEVEL_W'(rem >= HALF_W'(VOLUME_MAX));

	always_ff @(posedge clk) begin
		if (cmd.div1) begin
			y_s2  <= acc_q[SUM_W-1:1];
			q0_s2 <= recip_prod[RECIP_SHIFT +: LEVEL_W];
		end
		if (cmd.div2)
			level_q <= (quot > LEVEL_W'(OUTPUT_MAX)) ? SAMPLE_W'(OUTPUT_MAX) : quot[SAMPLE_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.dac_sample <= cmd.out_muted ? '0 : level_q;
			out_q.muted      <= cmd.out_muted;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign sts.mute     = mute_q;
	assign sts.out_free = !out_valid_q || !result_stall;

	`ASSERT_CLK(a_load_sets_valid, clk, arst_n,
		cmd.load_out |=> out_valid_q,
		"loaded word not presented")
	`ASSERT_NEVER(a_muted_nonzero, clk, arst_n,
		out_valid_q && out_q.muted && out_q.dac_sample != '0,
		"muted word carries a nonzero sample")
	`ASSERT_NEVER(a_load_over_full, clk, arst_n,
		cmd.load_out && out_valid_q && result_stall,
		"output overwritten while stalled")

endmodule
